@@ src/ttip_pkg.sv @@
// ----------------------------------------------------------------------------
// ttip_pkg: shared definitions for the text to integer parser
// parse phase, radix and character codes and character classification helpers
// ----------------------------------------------------------------------------
`default_nettype none

package ttip_pkg;

	// default widths of the result fields
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 16;

	// parse phase codes
	localparam logic [2:0] PH_DONE   = 3'd0;
	localparam logic [2:0] PH_SPACE  = 3'd1;
	localparam logic [2:0] PH_FIRST  = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	// radix codes
	localparam logic [4:0] BASE_AUTO = 5'd0;
	localparam logic [4:0] BASE_OCT  = 5'd8;
	localparam logic [4:0] BASE_DEC  = 5'd10;
	localparam logic [4:0] BASE_HEX  = 5'd16;

	// character codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;

	// digit value for a non-digit; it is never below any 5-bit radix
	localparam logic [4:0] NO_DIGIT = 5'h1f;

	typedef logic [7:0] char_t;
	typedef logic [4:0] digit_t;

	function automatic logic is_blank(input char_t c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_CR) || (c == CH_FF) || (c == CH_VT);
	endfunction

	function automatic digit_t digit_of(input char_t c);
		char_t off;
		off = '0;
		if (c >= CH_0 && c <= CH_9) begin
			off = c - CH_0;
			return off[4:0];
		end
		if (c >= CH_LO_A && c <= CH_LO_F) begin
			off = c - CH_LO_A + 8'd10;
			return off[4:0];
		end
		if (c >= CH_UP_A && c <= CH_UP_F) begin
			off = c - CH_UP_A + 8'd10;
			return off[4:0];
		end
		return NO_DIGIT;
	endfunction

endpackage

`default_nettype wire

@@ src/text_to_integer_parser_core.sv @@
// ----------------------------------------------------------------------------
// text_to_integer_parser_core: streaming signed integer parser
// one character per transaction in, one signed value and consumed count out
// when the scan of a string stops
// ----------------------------------------------------------------------------
// usage
//   input channel: char_valid / char_stall with char_code, start_of_string
//   and base_request. a transaction with start_of_string high opens a new
//   string and samples base_request (0 selects the radix from the prefix).
//   leading blanks, one sign and an optional 0x / 0 prefix are consumed,
//   then digits accumulate as acc*base+digit, wrapping at VALUE_WIDTH bits.
//   output channel: result_valid / result_stall with parsed_value and
//   consumed_count. at most one result transaction leaves per string, on the
//   character that stops the scan (nul, non-digit or digit not below radix);
//   later characters up to the next string start are dropped silently, and a
//   string cut by a new string start before it stops leaves no result.
//   path: a stopping character goes through the input register, then the
//   result register. throughput: one character per cycle unless a result
//   is held stalled; the state update is a single 5-bit by VALUE_WIDTH
//   multiply-add between the input register and the parse state registers.
//   result stall: the result register holds its transaction, the input
//   register fills, and char_stall rises until the result is taken.
//   reset: arst_n low empties both registers and leaves the parser idle,
//   ignoring characters until a string start.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_integer_parser_core #(
	parameter int VALUE_WIDTH = ttip_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = ttip_pkg::COUNT_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// character input channel
	input  wire                          char_valid,
	output logic                         char_stall,
	input  wire  [7:0]                   char_code,
	input  wire                          start_of_string,
	input  wire  [4:0]                   base_request,
	// result output channel
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic signed [VALUE_WIDTH-1:0] parsed_value,
	output logic [COUNT_WIDTH-1:0]       consumed_count
);
	import ttip_pkg::*;

	// input register stage
	logic        valid_s1;
	char_t       char_s1;
	logic        start_s1;
	logic [4:0]  base_s1;

	// parse state
	logic [2:0]              phase_q;
	logic                    neg_q;
	logic [4:0]              base_q;
	logic                    auto_q;
	logic [VALUE_WIDTH-1:0]  acc_q;
	logic [COUNT_WIDTH-1:0]  cnt_q;

	// result register
	logic                    result_valid_q;
	logic [VALUE_WIDTH-1:0]  value_q;
	logic [COUNT_WIDTH-1:0]  count_q;

	// next state
	logic [2:0]              phase_n;
	logic                    neg_n;
	logic [4:0]              base_n;
	logic                    auto_n;
	logic [VALUE_WIDTH-1:0]  acc_n;
	logic [COUNT_WIDTH-1:0]  cnt_n;
	logic [COUNT_WIDTH-1:0]  cnt_start;
	logic [COUNT_WIDTH-1:0]  cnt_inc;
	logic                    emit;
	logic                    go;
	digit_t                  dig;

	// the parse step may run unless a finished result is still held
	logic advance;
	assign advance    = !(result_valid_q && result_stall);
	assign char_stall = valid_s1 && !advance;

	// a new string restarts the count from zero; the count saturates
	assign cnt_start = start_s1 ? '0 : cnt_q;
	assign cnt_inc   = (cnt_start == {COUNT_WIDTH{1'b1}}) ? cnt_start : cnt_start + 1'b1;

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		base_n  = base_q;
		auto_n  = auto_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		emit    = 1'b0;
		go      = 1'b1;
		dig     = digit_of(char_s1);

		// string start: fresh parse, radix sampled here
		if (start_s1) begin
			phase_n = PH_SPACE;
			neg_n   = 1'b0;
			base_n  = base_s1;
			auto_n  = (base_s1 == BASE_AUTO);
			acc_n   = '0;
			cnt_n   = '0;
		end

		// idle between strings
		if (phase_n == PH_DONE) begin
			go = 1'b0;
		end

		// leading blanks and optional sign
		if (go && phase_n == PH_SPACE) begin
			if (is_blank(char_s1)) begin
				cnt_n = cnt_inc;
				go    = 1'b0;
			end else begin
				phase_n = PH_FIRST;
				if (char_s1 == CH_MINUS) begin
					neg_n = 1'b1;
					cnt_n = cnt_inc;
					go    = 1'b0;
				end else if (char_s1 == CH_PLUS) begin
					cnt_n = cnt_inc;
					go    = 1'b0;
				end
			end
		end

		// first significant character: a zero may open a radix prefix
		if (go && phase_n == PH_FIRST) begin
			if ((auto_n || base_n == BASE_HEX) && char_s1 == CH_0) begin
				cnt_n   = cnt_inc;
				phase_n = PH_ZERO;
				go      = 1'b0;
			end else begin
				if (auto_n) begin
					base_n = BASE_DEC;
				end
				phase_n = PH_DIGITS;
			end
		end

		// after a leading zero: x selects hex, anything else falls to digits
		if (go && phase_n == PH_ZERO) begin
			if (char_s1 == CH_LO_X || char_s1 == CH_UP_X) begin
				base_n  = BASE_HEX;
				cnt_n   = cnt_inc;
				phase_n = PH_DIGITS;
				go      = 1'b0;
			end else begin
				if (auto_n) begin
					base_n = BASE_OCT;
				end
				phase_n = PH_DIGITS;
			end
		end

		// digit accumulation, or stop and emit
		if (go) begin
			if (phase_n != PH_DIGITS || dig == NO_DIGIT || dig >= base_n) begin
				emit    = 1'b1;
				phase_n = PH_DONE;
			end else begin
				acc_n = acc_n * VALUE_WIDTH'(base_n) + VALUE_WIDTH'(dig);
				cnt_n = cnt_inc;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1  <= char_code;
			start_s1 <= start_of_string;
			base_s1  <= base_request;
		end
	end

	// parse state, updated once per character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			neg_q   <= 1'b0;
			base_q  <= BASE_AUTO;
			auto_q  <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (valid_s1 && advance) begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			base_q  <= base_n;
			auto_q  <= auto_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			value_q <= neg_n ? (~acc_n + 1'b1) : acc_n;
			count_q <= cnt_n;
		end
	end

	assign result_valid   = result_valid_q;
	assign parsed_value   = $signed(value_q);
	assign consumed_count = count_q;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for text_to_integer_parser_core
// streams characters into the parser, predicts each parse result in a model
// of the scan kept here, and checks every result transaction field by field
// under several patterns of sender gaps and result stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import ttip_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam int CW = COUNT_WIDTH_DEF;

	// cycles with no transaction on either channel before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// pipeline depth plus margin, waited out once the last result is in
	localparam int DRAIN_CYCLES = 8;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TOP = 8'hff;
	localparam logic [CW-1:0] COUNT_SAT = {CW{1'b1}};
	// marks a character that is no digit at all
	localparam logic [4:0] NOT_A_DIGIT = 5'h1f;

	typedef struct {
		logic [VW-1:0] value;
		logic [CW-1:0] count;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic char_valid = 1'b0;
	logic char_stall;
	logic [7:0] char_code = '0;
	logic start_of_string = 1'b0;
	logic [4:0] base_request = '0;

	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [VW-1:0] parsed_value;
	logic [CW-1:0] consumed_count;

	// percentages that shape the traffic of the current phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int error_count = 0;
	int quiet_cycles = 0;

	// results still owed by the parser, oldest first
	parse_result_t pending_parses[$];

	// scan state as the parser should hold it
	logic [2:0] scan_phase = PH_DONE;
	logic scan_negative = 1'b0;
	logic [4:0] scan_radix = '0;
	logic scan_auto = 1'b0;
	logic [VW-1:0] scan_acc = '0;
	logic [CW-1:0] scan_count = '0;

	text_to_integer_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.start_of_string(start_of_string),
		.base_request(base_request),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.parsed_value(parsed_value),
		.consumed_count(consumed_count)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// scan model
	// ------------------------------------------------------------------

	// space, and tab through carriage return (tab, lf, vt, ff, cr)
	function automatic logic char_is_space(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// digits keep their value in the low nibble, letters a-f add nine to it
	function automatic logic [4:0] char_digit(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) begin
			return {1'b0, c[3:0]};
		end
		if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
			return {1'b0, c[3:0]} + 5'd9;
		end
		return NOT_A_DIGIT;
	endfunction

	task automatic bump_count;
		if (scan_count != COUNT_SAT)
			scan_count = scan_count + 1'b1;
	endtask

	// advance the scan by one accepted character, queue a result when it stops
	task automatic scan_char(input logic [7:0] c, input logic fresh, input logic [4:0] breq);
		logic [4:0] d;
		parse_result_t res;
		if (fresh) begin
			scan_phase = PH_SPACE;
			scan_negative = 1'b0;
			scan_radix = breq;
			scan_auto = (breq == BASE_AUTO);
			scan_acc = '0;
			scan_count = '0;
		end
		if (scan_phase == PH_DONE)
			return;
		if (scan_phase == PH_SPACE) begin
			if (char_is_space(c)) begin
				bump_count();
				return;
			end
			scan_phase = PH_FIRST;
			if (c == CH_MINUS || c == CH_PLUS) begin
				scan_negative = (c == CH_MINUS);
				bump_count();
				return;
			end
		end
		if (scan_phase == PH_FIRST) begin
			if ((scan_auto || scan_radix == BASE_HEX) && c == CH_0) begin
				bump_count();
				scan_phase = PH_ZERO;
				return;
			end
			if (scan_auto)
				scan_radix = BASE_DEC;
			scan_phase = PH_DIGITS;
		end
		if (scan_phase == PH_ZERO) begin
			if (c == CH_LO_X || c == CH_UP_X) begin
				scan_radix = BASE_HEX;
				bump_count();
				scan_phase = PH_DIGITS;
				return;
			end
			if (scan_auto)
				scan_radix = BASE_OCT;
			scan_phase = PH_DIGITS;
		end
		d = char_digit(c);
		if (d == NOT_A_DIGIT || d >= scan_radix) begin
			res.value = scan_negative ? -scan_acc : scan_acc;
			res.count = scan_count;
			pending_parses.push_back(res);
			scan_phase = PH_DONE;
			return;
		end
		scan_acc = scan_acc * VW'(scan_radix) + VW'(d);
		bump_count();
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// one character transaction; payload holds while stalled
	task automatic send_char(input logic [7:0] c, input logic fresh, input logic [4:0] breq);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			char_valid = 1'b0;
			char_code = 8'($urandom);
			@(negedge clk);
		end
		char_valid = 1'b1;
		char_code = c;
		start_of_string = fresh;
		base_request = breq;
		@(posedge clk);
		while (char_stall !== 1'b0)
			@(posedge clk);
		scan_char(c, fresh, breq);
	endtask

	// text then a stopping character; base_request is noise off the start
	task automatic send_text(input logic [4:0] breq, input string text,
		input logic [7:0] stop_ch, input logic fresh);
		int i;
		for (i = 0; i < text.len(); i++) begin
			send_char(text[i], fresh && i == 0, (fresh && i == 0) ? breq : 5'($urandom));
		end
		send_char(stop_ch, fresh && text.len() == 0, 5'($urandom));
	endtask

	// a digit character below the radix, letters in either case
	function automatic logic [7:0] digit_char(input logic [4:0] radix);
		int lim;
		int v;
		lim = (radix > 5'd16) ? 16 : int'(radix);
		v = $urandom_range(0, lim - 1);
		if (v < 10)
			return CH_0 + 8'(v);
		return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] space_char;
		logic [7:0] spaces[6];
		spaces = '{CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		return spaces[$urandom_range(0, 5)];
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// parser comes out of reset idle: characters without a start are dropped
	task automatic test_idle_after_reset;
		send_text(BASE_DEC, "12", CH_NUL, 1'b0);
		send_char(CH_TOP, 1'b0, 5'h1f);
	endtask

	task automatic test_directed_strings;
		// every blank, then a sign and decimal digits
		send_char(CH_SP, 1'b1, BASE_AUTO);
		send_char(CH_TAB, 1'b0, 5'($urandom));
		send_char(CH_LF, 1'b0, 5'($urandom));
		send_char(CH_CR, 1'b0, 5'($urandom));
		send_char(CH_FF, 1'b0, 5'($urandom));
		send_char(CH_VT, 1'b0, 5'($urandom));
		send_text(BASE_AUTO, "-123", CH_NUL, 1'b0);
		// value extremes with hex prefixes in both cases
		send_text(BASE_AUTO, "+0x7fffffff", CH_NUL, 1'b1);
		send_text(BASE_HEX, "-0X80000000", CH_NUL, 1'b1);
		send_text(BASE_HEX, "FFFFFFFFFF", CH_NUL, 1'b1);
		// leading zero picks octal, eight stops it
		send_text(BASE_AUTO, "0777", "8", 1'b1);
		// prefix with no hex digit behind it
		send_text(BASE_AUTO, "0x", "g", 1'b1);
		// blank after the sign ends the scan
		send_text(BASE_AUTO, "-", CH_SP, 1'b1);
		// radix one only takes zeros
		send_text(5'd1, "000", "1", 1'b1);
		// radix above sixteen: all digits count, no prefix
		send_text(5'd31, "fF9", "z", 1'b1);
		send_text(5'd17, "0", "x", 1'b1);
		// decimal request does not know the prefix
		send_text(BASE_DEC, "0", "X", 1'b1);
		send_text(5'd2, "1011", "2", 1'b1);
		// high codes are no digits
		send_text(BASE_AUTO, "", 8'h80, 1'b1);
		send_text(BASE_AUTO, "", CH_TOP, 1'b1);
		// a new start drops the open scan
		send_text(BASE_DEC, "12", "3", 1'b1);
		send_text(BASE_DEC, "45", CH_NUL, 1'b1);
		// characters after the stop change nothing
		send_text(BASE_DEC, "99", CH_NUL, 1'b0);
	endtask

	// mostly well-formed numbers with random content, some broken strings
	task automatic test_random_strings(input int send_pct, input int stall_pct, input int n_chars);
		logic [7:0] word[$];
		logic [4:0] breq;
		logic [4:0] radix;
		int sent;
		int shape;
		int r;
		int i;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_chars) begin
			word.delete();
			shape = $urandom_range(0, 99);
			r = $urandom_range(0, 99);
			if (r < 30)
				breq = BASE_AUTO;
			else if (r < 45)
				breq = BASE_HEX;
			else if (r < 60)
				breq = BASE_DEC;
			else if (r < 70)
				breq = BASE_OCT;
			else if (r < 90)
				breq = 5'($urandom_range(1, 16));
			else
				breq = 5'($urandom_range(17, 31));
			radix = (breq == BASE_AUTO) ? BASE_DEC : breq;
			repeat ($urandom_range(0, 3))
				word.push_back(space_char());
			r = $urandom_range(0, 3);
			if (r == 0)
				word.push_back(CH_MINUS);
			else if (r == 1)
				word.push_back(CH_PLUS);
			if ((breq == BASE_AUTO || breq == BASE_HEX) && $urandom_range(0, 2) == 0) begin
				word.push_back(CH_0);
				word.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LO_X);
				radix = BASE_HEX;
			end else if (breq == BASE_AUTO && $urandom_range(0, 3) == 0) begin
				word.push_back(CH_0);
				radix = BASE_OCT;
			end
			repeat ($urandom_range(0, 12))
				word.push_back(digit_char(radix));
			// stopping character unless this string is cut by the next start
			if (shape >= 10 && shape < 18) begin
			end else if ($urandom_range(0, 1))
				word.push_back(CH_NUL);
			else
				word.push_back(8'($urandom));
			// corrupt one character
			if (shape < 10 && word.size() > 0)
				word[$urandom_range(0, word.size() - 1)] = 8'($urandom);
			for (i = 0; i < word.size(); i++) begin
				send_char(word[i], i == 0, (i == 0) ? breq : 5'($urandom));
			end
			sent += word.size();
			// trailing characters the parser ignores
			if (shape >= 18 && shape < 26) begin
				repeat ($urandom_range(1, 4))
					send_char(8'($urandom), 1'b0, 5'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// random stall pattern of the current phase
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// each result transaction against the oldest expected parse
	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_parses.size() == 0) begin
				$display("%0t: unexpected result value %0d count %0d",
					$time, parsed_value, consumed_count);
				error_count++;
			end else begin
				want = pending_parses.pop_front();
				if (parsed_value !== want.value) begin
					$display("%0t: parsed_value expected %0d actual %0d",
						$time, $signed(want.value), parsed_value);
					error_count++;
				end
				if (consumed_count !== want.count) begin
					$display("%0t: consumed_count expected %0d actual %0d",
						$time, want.count, consumed_count);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_after_reset();
		test_directed_strings();
		test_random_strings(0, 0, 200);
		test_random_strings(52, 0, 200);
		test_random_strings(0, 52, 200);
		test_random_strings(6, 6, 200);

		@(negedge clk);
		char_valid = 1'b0;
		while (pending_parses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
